@@ sv/bsfr_pkg.sv @@
// Shared types and constants for the byte-stuffed frame receiver.
package bsfr_pkg;

  localparam int NUM_ENTRIES = 3;
  localparam int LEN_W       = 6;
  localparam int PADDR_W     = 5;

  localparam logic [7:0] HEAD_BYTE = 8'hFD;
  localparam logic [7:0] TAIL_BYTE = 8'hF8;
  localparam logic [7:0] ESC_BYTE  = 8'hFE;
  localparam logic [7:0] ESC_HEAD  = 8'h7D;
  localparam logic [7:0] ESC_TAIL  = 8'h78;
  localparam logic [7:0] ESC_ESC   = 8'h7E;

  // head, type, serial, checksum, tail
  localparam logic [LEN_W:0] LEN_OVERHEAD = 7'd5;

  localparam logic [1:0] ST_PAYLOAD  = 2'd0;
  localparam logic [1:0] ST_NO_MATCH = 2'd1;
  localparam logic [1:0] ST_BAD_SUM  = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  localparam logic [2:0] REG_E0_TYPE = 3'd0;
  localparam logic [2:0] REG_E0_LEN  = 3'd1;
  localparam logic [2:0] REG_E1_TYPE = 3'd2;
  localparam logic [2:0] REG_E1_LEN  = 3'd3;
  localparam logic [2:0] REG_E2_TYPE = 3'd4;
  localparam logic [2:0] REG_E2_LEN  = 3'd5;
  localparam logic [2:0] REG_CS_EN   = 3'd6;

  typedef struct packed {
    logic [NUM_ENTRIES-1:0][7:0]       entry_type;
    logic [NUM_ENTRIES-1:0][LEN_W-1:0] entry_len;
    logic                              checksum_en;
  } cfg_t;

endpackage

@@ sv/bsfr_cfg.sv @@
// APB configuration registers: type/length table and checksum enable.
module bsfr_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bsfr_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output bsfr_pkg::cfg_t               cfg_o
);
  import bsfr_pkg::*;

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] idx;

  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[4:2];
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int e = 0; e < NUM_ENTRIES; e++) begin
        cfg_q.entry_type[e] <= '0;
        cfg_q.entry_len[e]  <= LEN_W'(1);
      end
      cfg_q.checksum_en <= 1'b0;
    end else if (wr_en) begin
      case (idx)
        REG_E0_TYPE: cfg_q.entry_type[0] <= pwdata[7:0];
        REG_E0_LEN:  cfg_q.entry_len[0]  <= pwdata[LEN_W-1:0];
        REG_E1_TYPE: cfg_q.entry_type[1] <= pwdata[7:0];
        REG_E1_LEN:  cfg_q.entry_len[1]  <= pwdata[LEN_W-1:0];
        REG_E2_TYPE: cfg_q.entry_type[2] <= pwdata[7:0];
        REG_E2_LEN:  cfg_q.entry_len[2]  <= pwdata[LEN_W-1:0];
        REG_CS_EN:   cfg_q.checksum_en   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_E0_TYPE: prdata = 32'(cfg_q.entry_type[0]);
      REG_E0_LEN:  prdata = 32'(cfg_q.entry_len[0]);
      REG_E1_TYPE: prdata = 32'(cfg_q.entry_type[1]);
      REG_E1_LEN:  prdata = 32'(cfg_q.entry_len[1]);
      REG_E2_TYPE: prdata = 32'(cfg_q.entry_type[2]);
      REG_E2_LEN:  prdata = 32'(cfg_q.entry_len[2]);
      REG_CS_EN:   prdata = 32'(cfg_q.checksum_en);
      default:     prdata = '0;
    endcase
  end

endmodule

@@ sv/bsfr_store.sv @@
// Frame byte store: one write port, one registered read port.
module bsfr_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/byte_stuffed_frame_receiver.sv @@
// Top level: byte-stuffed frame receiver with sequencer, checksum adder and output register.
//
//  channel | signals                                    | direction
//  --------+--------------------------------------------+----------
//  in      | in_valid_i, in_ready_o, byte_in_i          | request in
//  out     | out_valid_o, out_ready_i, status_o .. last_o | request out
//  cfg     | psel, penable, pwrite, paddr, pwdata, prdata | APB slave
//
// A byte that neither ends nor overflows a frame is taken in S_IDLE; an overflow passes
// S_OVF_RD, S_OVF_CAP and S_ONE. A tail byte (after S_PUTTAIL if escaped) reads bytes 1 to
// n-2 (at least byte 1) through the single read port in S_SCAN_RD and S_SCAN_ACC (one shared
// 8-bit adder builds the checksum), matches in S_EVAL, then sends a status result from S_ONE
// or each payload byte via S_EMIT_RD/S_EMIT_WR. Output stalls hold the sequencer in place.
// Reset clears control state; the frame store is not cleared.
module byte_stuffed_frame_receiver #(
  parameter int FRAME_BUFFER_BYTES = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [7:0]                   byte_in_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   status_o,
  output logic [1:0]                   entry_index_o,
  output logic [7:0]                   frame_type_o,
  output logic [7:0]                   payload_byte_o,
  output logic [7:0]                   serial_number_o,
  output logic [7:0]                   checksum_byte_o,
  output logic                         last_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bsfr_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import bsfr_pkg::*;

  localparam int AW = $clog2(FRAME_BUFFER_BYTES);
  localparam int FW = $clog2(FRAME_BUFFER_BYTES + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_PUTTAIL, S_SCAN_RD, S_SCAN_ACC, S_EVAL,
    S_EMIT_RD, S_EMIT_WR, S_OVF_RD, S_OVF_CAP, S_ONE
  } state_e;

  state_e           state_q;
  logic             head_q, esc_q;
  logic [FW-1:0]    fill_q;
  logic [AW-1:0]    ptr_q;
  logic [7:0]       sum_q, typ_q, ser_q, chk_q;
  logic [1:0]       st_q, idx_q;
  logic [LEN_W-1:0] len_q, cnt_q;

  logic             out_valid_q, out_last_q;
  logic [1:0]       out_st_q, out_idx_q;
  logic [7:0]       out_typ_q, out_pay_q, out_ser_q, out_chk_q;

  cfg_t             cfg;
  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [7:0]       mem_wdata, rd_data;

  logic             accept, is_head, esc_now, do_store, tail_now, esc_tail, overflow;
  logic [7:0]       mapped;
  logic [FW-1:0]    base_fill;
  logic             full_now, slot_free;
  logic             n_ge5, sum_en, scan_done;
  logic [AW-1:0]    last_addr;
  logic             hit;
  logic [1:0]       hit_idx;
  logic             emit_last;
  logic             out_load;
  logic [1:0]       out_st_d, out_idx_d;
  logic [7:0]       out_pay_d;
  logic             out_last_d;

  bsfr_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  bsfr_store #(
    .DEPTH(FRAME_BUFFER_BYTES),
    .AW   (AW)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(rd_data)
  );

  // input byte decode
  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign is_head    = (byte_in_i == HEAD_BYTE);
  assign esc_now    = !is_head && esc_q;
  assign do_store   = is_head || (head_q && (esc_q || byte_in_i != ESC_BYTE));
  assign tail_now   = head_q && !is_head && !esc_q && (byte_in_i == TAIL_BYTE);
  assign esc_tail   = head_q && esc_now && (byte_in_i == TAIL_BYTE);
  assign base_fill  = is_head ? '0 : fill_q;
  assign full_now   = (fill_q == FW'(FRAME_BUFFER_BYTES));
  assign overflow   = do_store && (base_fill == FW'(FRAME_BUFFER_BYTES));

  always_comb begin
    mapped = byte_in_i;
    if (esc_now) begin
      case (byte_in_i)
        ESC_HEAD:  mapped = HEAD_BYTE;
        ESC_TAIL:  mapped = TAIL_BYTE;
        ESC_ESC:   mapped = ESC_BYTE;
        TAIL_BYTE: mapped = ESC_BYTE;
        default:   mapped = byte_in_i;
      endcase
    end
  end

  // scan bookkeeping
  assign n_ge5     = (fill_q >= FW'(LEN_OVERHEAD));
  assign sum_en    = ((FW+1)'(ptr_q) + (FW+1)'(3)) <= (FW+1)'(fill_q);
  assign last_addr = (fill_q >= FW'(4)) ? AW'(fill_q - FW'(2)) : AW'(1);
  assign scan_done = (ptr_q == last_addr);
  assign slot_free = !out_valid_q || out_ready_i;
  assign emit_last = ((cnt_q + LEN_W'(1)) == len_q);

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int e = 0; e < NUM_ENTRIES; e++) begin
      if (typ_q == cfg.entry_type[e] &&
          7'(fill_q) == ({1'b0, cfg.entry_len[e]} + LEN_OVERHEAD)) begin
        hit     = 1'b1;
        hit_idx = 2'(e);
      end
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = AW'(base_fill);
    mem_wdata = mapped;
    mem_re    = 1'b0;
    mem_raddr = ptr_q;
    unique case (state_q)
      S_IDLE:    mem_we = accept && do_store && !overflow;
      S_PUTTAIL: begin
        mem_we    = !full_now;
        mem_waddr = AW'(fill_q);
        mem_wdata = TAIL_BYTE;
      end
      S_SCAN_RD: mem_re = 1'b1;
      S_EMIT_RD: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(cnt_q + LEN_W'(2));
      end
      S_OVF_RD: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(1);
      end
      default: ;
    endcase
  end

  always_comb begin
    out_load   = 1'b0;
    out_st_d   = st_q;
    out_idx_d  = idx_q;
    out_pay_d  = '0;
    out_last_d = 1'b1;
    unique case (state_q)
      S_ONE:     out_load = slot_free;
      S_EMIT_WR: begin
        out_load   = slot_free;
        out_st_d   = ST_PAYLOAD;
        out_pay_d  = rd_data;
        out_last_d = emit_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= 1'b0;
      esc_q       <= 1'b0;
      fill_q      <= '0;
      ptr_q       <= '0;
      sum_q       <= '0;
      typ_q       <= '0;
      ser_q       <= '0;
      chk_q       <= '0;
      st_q        <= ST_PAYLOAD;
      idx_q       <= '0;
      len_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_st_q    <= ST_PAYLOAD;
      out_idx_q   <= '0;
      out_typ_q   <= '0;
      out_pay_q   <= '0;
      out_ser_q   <= '0;
      out_chk_q   <= '0;
      out_last_q  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_st_q    <= out_st_d;
        out_idx_q   <= out_idx_d;
        out_typ_q   <= typ_q;
        out_pay_q   <= out_pay_d;
        out_ser_q   <= ser_q;
        out_chk_q   <= chk_q;
        out_last_q  <= out_last_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (is_head) begin
              head_q <= 1'b1;
              esc_q  <= 1'b0;
              fill_q <= FW'(1);
            end else if (head_q) begin
              if (!esc_q && byte_in_i == ESC_BYTE) begin
                esc_q <= 1'b1;
              end else if (overflow) begin
                head_q  <= 1'b0;
                esc_q   <= 1'b0;
                fill_q  <= '0;
                state_q <= S_OVF_RD;
              end else begin
                esc_q  <= 1'b0;
                fill_q <= fill_q + FW'(1);
                if (esc_tail) begin
                  head_q  <= 1'b0;
                  state_q <= S_PUTTAIL;
                end else if (tail_now) begin
                  head_q  <= 1'b0;
                  ptr_q   <= AW'(1);
                  sum_q   <= '0;
                  ser_q   <= '0;
                  chk_q   <= '0;
                  state_q <= S_SCAN_RD;
                end
              end
            end
          end
        end
        S_PUTTAIL: begin
          if (full_now) begin
            fill_q  <= '0;
            state_q <= S_OVF_RD;
          end else begin
            fill_q  <= fill_q + FW'(1);
            ptr_q   <= AW'(1);
            sum_q   <= '0;
            ser_q   <= '0;
            chk_q   <= '0;
            state_q <= S_SCAN_RD;
          end
        end
        S_SCAN_RD: state_q <= S_SCAN_ACC;
        S_SCAN_ACC: begin
          if (ptr_q == AW'(1)) typ_q <= rd_data;
          if (sum_en) sum_q <= sum_q + rd_data;
          if (n_ge5 && FW'(ptr_q) == fill_q - FW'(3)) ser_q <= rd_data;
          if (n_ge5 && FW'(ptr_q) == fill_q - FW'(2)) chk_q <= rd_data;
          if (scan_done) begin
            state_q <= S_EVAL;
          end else begin
            ptr_q   <= ptr_q + AW'(1);
            state_q <= S_SCAN_RD;
          end
        end
        S_EVAL: begin
          idx_q <= hit_idx;
          len_q <= cfg.entry_len[hit_idx];
          cnt_q <= '0;
          if (!hit) begin
            st_q    <= ST_NO_MATCH;
            state_q <= S_ONE;
          end else if (cfg.checksum_en && sum_q != chk_q) begin
            st_q    <= ST_BAD_SUM;
            state_q <= S_ONE;
          end else if (cfg.entry_len[hit_idx] == '0) begin
            fill_q  <= '0;
            state_q <= S_IDLE;
          end else begin
            state_q <= S_EMIT_RD;
          end
        end
        S_EMIT_RD: state_q <= S_EMIT_WR;
        S_EMIT_WR: begin
          if (out_load) begin
            if (emit_last) begin
              fill_q  <= '0;
              state_q <= S_IDLE;
            end else begin
              cnt_q   <= cnt_q + LEN_W'(1);
              state_q <= S_EMIT_RD;
            end
          end
        end
        S_OVF_RD: state_q <= S_OVF_CAP;
        S_OVF_CAP: begin
          typ_q   <= rd_data;
          ser_q   <= '0;
          chk_q   <= '0;
          st_q    <= ST_OVERFLOW;
          idx_q   <= '0;
          state_q <= S_ONE;
        end
        S_ONE: begin
          if (out_load) begin
            fill_q  <= '0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_st_q;
  assign entry_index_o   = out_idx_q;
  assign frame_type_o    = out_typ_q;
  assign payload_byte_o  = out_pay_q;
  assign serial_number_o = out_ser_q;
  assign checksum_byte_o = out_chk_q;
  assign last_o          = out_last_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(FRAME_BUFFER_BYTES))
    else $error("fill count beyond buffer size");

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && !head_q) |-> (fill_q == '0))
    else $error("bytes held with no open frame");

  a_ovf_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_OVERFLOW) |->
      (payload_byte_o == '0 && entry_index_o == '0 && last_o))
    else $error("overflow result carries data");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_last_d) |=> (state_q == S_IDLE))
    else $error("sequencer busy after final result");

endmodule
